/* hdl/csi_rs_sequence_generator_macros.svh */
// ----------------------------------------------------------------------------
// CSI-RS sequence generator assertion macros
// Concurrent assertion wrappers shared by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef CSI_RS_SEQUENCE_GENERATOR_MACROS_SVH
`define CSI_RS_SEQUENCE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or sequence property on every rising clock edge.
`define CSIRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("csirs assertion failed");

// Check that a condition never holds at a rising clock edge.
`define CSIRS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("csirs forbidden condition seen");

`else

`define CSIRS_ASSERT(lbl, clk, rst, prop)
`define CSIRS_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hdl/csirs_pkg.sv */
// ----------------------------------------------------------------------------
// CSI-RS sequence generator package
// Shared types, constants and helper functions of the generator.
// ----------------------------------------------------------------------------
package csirs_pkg;

   localparam int WARMUP_BITS   = 1600;
   localparam int WARM_BASE     = WARMUP_BITS / 2;   // two Gold bits per cycle
   localparam int MAX_BLOCKS    = 275;
   localparam int INV_SQRT2_Q16 = 46341;
   localparam int GAIN_RESET    = 23170;
   localparam int RB_RESET      = 1;

   localparam int SEED_BASE_W  = 13;    // nsymb*slot + symbol + 1
   localparam int SEED_MULT_W  = 11;    // 2*id + 1
   localparam int SEED_PROD_W  = 21;    // product bits that survive mod 2^31
   localparam int SEED_STEPS   = SEED_MULT_W;
   localparam int SEED_CNT_W   = $clog2(SEED_STEPS + 1);
   localparam int LFSR_W       = 31;
   localparam int ADV_W        = 11;
   localparam int WARM_CNT_W   = 12;
   localparam int LEN_W        = 11;
   localparam int AMP_W        = 15;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DENS_ONE       = 2'd0,
      DENS_THREE     = 2'd1,
      DENS_HALF_EVEN = 2'd2,
      DENS_HALF_ODD  = 2'd3
   } density_type;

   typedef enum logic [1:0] {
      CDM_NONE    = 2'd0,
      CDM_FD2     = 2'd1,
      CDM_FD2_TD2 = 2'd2,
      CDM_FD2_TD4 = 2'd3
   } cdm_type;

   typedef enum logic [2:0] {
      REG_EXTENDED_CP      = 3'd0,
      REG_SCRAMBLING_IDENT = 3'd1,
      REG_DENSITY_MODE     = 3'd2,
      REG_FIRST_RB         = 3'd3,
      REG_RB_COUNT         = 3'd4,
      REG_SINGLE_RE_ROW    = 3'd5,
      REG_CDM_MODE         = 3'd6,
      REG_GAIN             = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SEED = 2'd1,
      ST_WARM = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
   } seed_ctrl_type;

   typedef struct packed {
      logic done;
   } seed_stat_type;

   typedef struct packed {
      logic load;
      logic advance;
   } gold_ctrl_type;

   // Amplitude gain/sqrt2 rounded: (gain*46341 + 32768) >> 16.
   function automatic logic [AMP_W-1:0] amp_of(input logic [14:0] gain);
      logic [31:0] prod;
      prod = 32'(gain) * 32'(INV_SQRT2_Q16) + 32'd32768;
      return prod[16 +: AMP_W];
   endfunction

   // nsymb*slot + symbol + 1, nsymb being 12 or 14.
   function automatic logic [SEED_BASE_W-1:0] seed_base(input logic ext_cp,
                                                        input logic [8:0] slot,
                                                        input logic [3:0] sym);
      logic [SEED_BASE_W-1:0] s;
      logic [SEED_BASE_W-1:0] scaled;
      s = SEED_BASE_W'(slot);
      if (ext_cp) begin
         scaled = (s << 3) + (s << 2);
      end else begin
         scaled = (s << 4) - (s << 1);
      end
      return scaled + SEED_BASE_W'(sym) + SEED_BASE_W'(1);
   endfunction

   // Gold elements to skip ahead of the first occupied RB.
   function automatic logic [ADV_W-1:0] advance_of(input density_type dens,
                                                   input logic [8:0] first_rb,
                                                   input logic single_re);
      logic [ADV_W-1:0] f;
      logic [ADV_W-1:0] adj;
      logic [ADV_W-1:0] adv;
      f = ADV_W'(first_rb);
      adj = f + ((dens == DENS_HALF_ODD) ? ADV_W'(!first_rb[0]) : ADV_W'(first_rb[0]));
      unique case (dens)
         DENS_ONE:       adv = single_re ? f : (f << 1);
         DENS_THREE:     adv = f + (f << 1);
         DENS_HALF_EVEN,
         DENS_HALF_ODD:  adv = single_re ? (adj >> 1) : adj;
      endcase
      return adv;
   endfunction

   // Elements in one symbol sequence.
   function automatic logic [LEN_W-1:0] seq_len_of(input density_type dens,
                                                   input cdm_type cdm,
                                                   input logic [8:0] first_rb,
                                                   input logic [8:0] rb_count);
      logic [8:0]       rb;
      logic [LEN_W-1:0] r;
      logic [LEN_W-1:0] len;
      logic             extra;
      rb = (rb_count > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : rb_count;
      r = LEN_W'(rb);
      extra = rb[0] & (first_rb[0] == (dens == DENS_HALF_ODD));
      unique case (dens)
         DENS_ONE:       len = r;
         DENS_THREE:     len = r + (r << 1);
         DENS_HALF_EVEN,
         DENS_HALF_ODD:  len = (r >> 1) + LEN_W'(extra);
      endcase
      if (cdm != CDM_NONE) begin
         len = len << 1;
      end
      return len;
   endfunction

   // CDM weight sign: 1 means the element is negated.
   function automatic logic weight_neg(input cdm_type cdm, input logic [2:0] port,
                                       input logic [1:0] sym, input logic k);
      logic neg;
      unique case (cdm)
         CDM_NONE:    neg = 1'b0;
         CDM_FD2:     neg = port[0] & k;
         CDM_FD2_TD2: neg = (port[0] & k) ^ (port[1] & sym[0]);
         CDM_FD2_TD4: neg = (port[0] & k) ^ (port[1] & sym[0]) ^ (port[2] & sym[1]);
      endcase
      return neg;
   endfunction

endpackage

/* hdl/csirs_seed.sv */
// ----------------------------------------------------------------------------
// CSI-RS seed multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, for the Gold seed.
// ----------------------------------------------------------------------------
module csirs_seed (
   input  logic                                  clock,
   input  logic                                  reset,
   input  csirs_pkg::seed_ctrl_type              ctrl,
   input  logic [csirs_pkg::SEED_BASE_W-1:0]     base,
   input  logic [csirs_pkg::SEED_MULT_W-1:0]     mult,
   output csirs_pkg::seed_stat_type              stat,
   output logic [csirs_pkg::SEED_PROD_W-1:0]     product
);

   logic [csirs_pkg::SEED_CNT_W-1:0]  cnt_ff;
   logic                              done_ff;
   logic [csirs_pkg::SEED_PROD_W-1:0] a_ff;
   logic [csirs_pkg::SEED_MULT_W-1:0] b_ff;
   logic [csirs_pkg::SEED_PROD_W-1:0] acc_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == csirs_pkg::SEED_CNT_W'(1));
         if (ctrl.load) begin
            cnt_ff <= csirs_pkg::SEED_CNT_W'(csirs_pkg::SEED_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - csirs_pkg::SEED_CNT_W'(1);
         end
      end
   end

   // datapath: add shifted multiplicand for each set multiplier bit
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff   <= csirs_pkg::SEED_PROD_W'(base);
         b_ff   <= mult;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

/* hdl/csirs_gold.sv */
// ----------------------------------------------------------------------------
// CSI-RS Gold generator
// Two length-31 LFSRs stepped two bits per cycle while advance is set.
// ----------------------------------------------------------------------------
module csirs_gold (
   input  logic                            clock,
   input  logic                            reset,
   input  csirs_pkg::gold_ctrl_type        ctrl,
   input  logic [csirs_pkg::LFSR_W-1:0]    seed,
   output logic [1:0]                      bits
);

   logic [csirs_pkg::LFSR_W-1:0] x1_ff;
   logic [csirs_pkg::LFSR_W-1:0] x2_ff;
   logic [csirs_pkg::LFSR_W-1:0] x1_in;
   logic [csirs_pkg::LFSR_W-1:0] x2_in;

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      if (ctrl.load) begin
         x1_in = csirs_pkg::LFSR_W'(1);
         x2_in = seed;
      end else if (ctrl.advance) begin
         x1_in = {x1_ff[1] ^ x1_ff[4], x1_ff[0] ^ x1_ff[3], x1_ff[30:2]};
         x2_in = {x2_ff[1] ^ x2_ff[2] ^ x2_ff[3] ^ x2_ff[4],
                  x2_ff[0] ^ x2_ff[1] ^ x2_ff[2] ^ x2_ff[3], x2_ff[30:2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= csirs_pkg::LFSR_W'(1);
         x2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

   // bit 0 is c(2n), bit 1 is c(2n+1)
   assign bits = {x1_ff[1] ^ x2_ff[1], x1_ff[0] ^ x2_ff[0]};

endmodule

/* hdl/csi_rs_sequence_generator.sv */
// ----------------------------------------------------------------------------
// CSI-RS sequence generator
// Gold-sequence QPSK generator with CDM weighting for NR CSI-RS symbols.
// ----------------------------------------------------------------------------
// A start beat (op 0) seeds the Gold generator from slot, symbol and the
// scrambling identity, and latches the CDM port and CDM symbol. The block then
// stalls the request side through the bit-serial seed multiplier, the LFSR
// load, and the walk of the LFSRs two bits per cycle through the 1600-bit
// warm-up and the RB offset (the offset is at most 1533 elements). A next beat
// (op 1) returns one QPSK element; next beats may follow every cycle, since the
// output register frees up when its beat is taken. Next beats past the end of
// the sequence are taken and return nothing. Configure only while no start is
// in progress and no response is pending.
// ----------------------------------------------------------------------------
`include "csi_rs_sequence_generator_macros.svh"

module csi_rs_sequence_generator (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [8:0]         req_slot_number,
   input  logic [3:0]         req_symbol_number,
   input  logic [2:0]         req_cdm_port,
   input  logic [1:0]         req_cdm_symbol,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_re_part,
   output logic signed [15:0] rsp_im_part,
   output logic               rsp_last,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // ---------------------------------------------------------------- registers
   logic                             ext_cp_ff;
   logic [9:0]                       ident_ff;
   csirs_pkg::density_type           density_ff;
   logic [8:0]                       first_rb_ff;
   logic [8:0]                       rb_count_ff;
   logic                             single_re_ff;
   csirs_pkg::cdm_type               cdm_ff;
   logic [14:0]                      gain_ff;
   logic [csirs_pkg::AMP_W-1:0]      amp_ff;

   logic                             csr_wr;
   csirs_pkg::csr_index_type         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csirs_pkg::csr_index_type'(csr_paddr[4:2]);

   // Amplitude is refreshed at the same edge as gain, so it is ready for the
   // very next beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_cp_ff    <= 1'b0;
         ident_ff     <= '0;
         density_ff   <= csirs_pkg::DENS_ONE;
         first_rb_ff  <= '0;
         rb_count_ff  <= 9'(csirs_pkg::RB_RESET);
         single_re_ff <= 1'b0;
         cdm_ff       <= csirs_pkg::CDM_NONE;
         gain_ff      <= 15'(csirs_pkg::GAIN_RESET);
         amp_ff       <= csirs_pkg::amp_of(15'(csirs_pkg::GAIN_RESET));
      end else if (csr_wr) begin
         unique case (csr_idx)
            csirs_pkg::REG_EXTENDED_CP:      ext_cp_ff    <= csr_pwdata[0];
            csirs_pkg::REG_SCRAMBLING_IDENT: ident_ff     <= csr_pwdata[9:0];
            csirs_pkg::REG_DENSITY_MODE:
               density_ff <= csirs_pkg::density_type'(csr_pwdata[1:0]);
            csirs_pkg::REG_FIRST_RB:         first_rb_ff  <= csr_pwdata[8:0];
            csirs_pkg::REG_RB_COUNT:         rb_count_ff  <= csr_pwdata[8:0];
            csirs_pkg::REG_SINGLE_RE_ROW:    single_re_ff <= csr_pwdata[0];
            csirs_pkg::REG_CDM_MODE:
               cdm_ff <= csirs_pkg::cdm_type'(csr_pwdata[1:0]);
            csirs_pkg::REG_GAIN: begin
               gain_ff <= csr_pwdata[14:0];
               amp_ff  <= csirs_pkg::amp_of(csr_pwdata[14:0]);
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         csirs_pkg::REG_EXTENDED_CP:      csr_prdata = 32'(ext_cp_ff);
         csirs_pkg::REG_SCRAMBLING_IDENT: csr_prdata = 32'(ident_ff);
         csirs_pkg::REG_DENSITY_MODE:     csr_prdata = 32'(density_ff);
         csirs_pkg::REG_FIRST_RB:         csr_prdata = 32'(first_rb_ff);
         csirs_pkg::REG_RB_COUNT:         csr_prdata = 32'(rb_count_ff);
         csirs_pkg::REG_SINGLE_RE_ROW:    csr_prdata = 32'(single_re_ff);
         csirs_pkg::REG_CDM_MODE:         csr_prdata = 32'(cdm_ff);
         csirs_pkg::REG_GAIN:             csr_prdata = 32'(gain_ff);
      endcase
   end

   // ---------------------------------------------------------------- control
   csirs_pkg::state_type                state_ff;
   csirs_pkg::state_type                state_in;
   logic [csirs_pkg::WARM_CNT_W-1:0]    warm_cnt_ff;
   logic [csirs_pkg::LEN_W-1:0]         idx_ff;
   logic [csirs_pkg::LEN_W-1:0]         len_ff;
   logic [2:0]                          port_ff;
   logic [1:0]                          csym_ff;

   logic                                req_accept;
   logic                                start_acc;
   logic                                next_acc;
   logic                                emit;

   csirs_pkg::seed_ctrl_type            seed_ctrl;
   csirs_pkg::seed_stat_type            seed_stat;
   logic [csirs_pkg::SEED_PROD_W-1:0]   seed_prod;
   csirs_pkg::gold_ctrl_type            gold_ctrl;
   logic [1:0]                          gold_bits;

   logic                                rsp_valid_ff;
   logic signed [15:0]                  rsp_re_ff;
   logic signed [15:0]                  rsp_im_ff;
   logic                                rsp_last_ff;

   // Take beats only while idle and with room in the output register.
   assign req_stall  = (state_ff != csirs_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign start_acc  = req_accept && (req_op == csirs_pkg::OP_START);
   assign next_acc   = req_accept && (req_op == csirs_pkg::OP_NEXT);
   // drop next beats past the end of the sequence
   assign emit       = next_acc && (idx_ff < len_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csirs_pkg::ST_IDLE: begin
            if (start_acc) begin
               state_in = csirs_pkg::ST_SEED;
            end
         end
         csirs_pkg::ST_SEED: begin
            if (seed_stat.done) begin
               state_in = csirs_pkg::ST_WARM;
            end
         end
         csirs_pkg::ST_WARM: begin
            if (warm_cnt_ff == csirs_pkg::WARM_CNT_W'(1)) begin
               state_in = csirs_pkg::ST_IDLE;
            end
         end
         default: state_in = csirs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csirs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence bookkeeping: latch on start, advance the index per element.
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_cnt_ff <= '0;
         idx_ff      <= '0;
         len_ff      <= '0;
         port_ff     <= '0;
         csym_ff     <= '0;
      end else begin
         if (start_acc) begin
            warm_cnt_ff <= csirs_pkg::WARM_CNT_W'(csirs_pkg::WARM_BASE)
                         + csirs_pkg::WARM_CNT_W'(csirs_pkg::advance_of(density_ff,
                              first_rb_ff, single_re_ff));
            idx_ff      <= '0;
            len_ff      <= csirs_pkg::seq_len_of(density_ff, cdm_ff, first_rb_ff,
                                                 rb_count_ff);
            port_ff     <= req_cdm_port;
            csym_ff     <= req_cdm_symbol;
         end else begin
            if (state_ff == csirs_pkg::ST_WARM) begin
               warm_cnt_ff <= warm_cnt_ff - csirs_pkg::WARM_CNT_W'(1);
            end
            if (emit) begin
               idx_ff <= idx_ff + csirs_pkg::LEN_W'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------- seed
   assign seed_ctrl.load = start_acc;

   csirs_seed u_seed (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (seed_ctrl),
      .base    (csirs_pkg::seed_base(ext_cp_ff, req_slot_number, req_symbol_number)),
      .mult    ({ident_ff, 1'b1}),
      .stat    (seed_stat),
      .product (seed_prod)
   );

   // ---------------------------------------------------------------- gold
   // c_init = {product mod 2^21, id}: the 1024 factor clears the low ten bits.
   assign gold_ctrl.load    = (state_ff == csirs_pkg::ST_SEED) && seed_stat.done;
   assign gold_ctrl.advance = (state_ff == csirs_pkg::ST_WARM) || emit;

   csirs_gold u_gold (
      .clock (clock),
      .reset (reset),
      .ctrl  (gold_ctrl),
      .seed  ({seed_prod, ident_ff}),
      .bits  (gold_bits)
   );

   // ---------------------------------------------------------------- output
   logic               neg;
   logic signed [15:0] amp_pos;
   logic signed [15:0] amp_neg;

   assign neg     = csirs_pkg::weight_neg(cdm_ff, port_ff, csym_ff, idx_ff[0]);
   assign amp_pos = signed'({1'b0, amp_ff});
   assign amp_neg = -amp_pos;

   // Hold the beat while stalled, load a fresh element on emit.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_re_ff   <= (gold_bits[0] ^ neg) ? amp_neg : amp_pos;
         rsp_im_ff   <= (gold_bits[1] ^ neg) ? amp_neg : amp_pos;
         rsp_last_ff <= ((idx_ff + csirs_pkg::LEN_W'(1)) == len_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_re_part = rsp_re_ff;
   assign rsp_im_part = rsp_im_ff;
   assign rsp_last    = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `CSIRS_ASSERT(a_emit_gives_beat, clock, reset, emit |=> rsp_valid)
   `CSIRS_ASSERT(a_warm_count_live, clock, reset, (state_ff == csirs_pkg::ST_WARM) |-> (warm_cnt_ff != '0))
   `CSIRS_ASSERT(a_seed_done_in_seed, clock, reset, seed_stat.done |-> (state_ff == csirs_pkg::ST_SEED))
   `CSIRS_ASSERT_NEVER(a_index_past_length, clock, reset, idx_ff > len_ff)

endmodule

/* sim/csi_rs_sequence_generator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSI-RS sequence generator testbench
// Drives start and next beats through the request channel and programs the
// registers over the APB port between phases. A tracker class keeps its own
// Gold generator, CDM weighting and sequence bookkeeping and checks every
// returned QPSK element field by field. The request channel idles and the response channel stalls at random.
// ----------------------------------------------------------------------------
module csi_rs_sequence_generator_test;
   import csirs_pkg::*;

   // Quiet cycles tolerated before the run is declared hung. A start beat
   // holds the request side through seed, load and warm-up, and the settle pause
   // adds to that, so leave ample headroom above both.
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   // Worst-case start latency (seed + load + warm-up + largest offset) plus
   // margin. Wait this long before touching registers and at the end.
   localparam int unsigned SETTLE_CYCLES  = 2600;
   localparam int unsigned ITEM_GOAL      = 1150;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
   } qpsk_elem_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_style_type;

   // -------------------------------------------------------------------------
   // Tracker: a private copy of the registers and the generator state. Every
   // accepted request beat advances it; every produced element is queued and
   // matched in order against the response channel.
   // -------------------------------------------------------------------------
   class csirs_sequence_tracker;
      logic        ext_cp;
      logic [9:0]  scr_id;
      density_type density;
      logic [8:0]  first_rb;
      logic [8:0]  rb_count;
      logic        single_re;
      cdm_type     cdm;
      logic [14:0] gain;

      logic [30:0] x1;
      logic [30:0] x2;
      logic [10:0] elem_idx;
      logic [10:0] seq_len;
      logic [2:0]  port_held;
      logic [1:0]  csym_held;

      qpsk_elem_type awaited[$];
      int unsigned   errors;

      function new();
         ext_cp    = 1'b0;
         scr_id    = '0;
         density   = DENS_ONE;
         first_rb  = '0;
         rb_count  = 9'(RB_RESET);
         single_re = 1'b0;
         cdm       = CDM_NONE;
         gain      = 15'(GAIN_RESET);
         x1        = 31'd1;
         x2        = '0;
         elem_idx  = '0;
         seq_len   = '0;
         port_held = '0;
         csym_held = '0;
         errors    = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            REG_EXTENDED_CP:      ext_cp    = value[0];
            REG_SCRAMBLING_IDENT: scr_id    = value[9:0];
            REG_DENSITY_MODE:     density   = density_type'(value[1:0]);
            REG_FIRST_RB:         first_rb  = value[8:0];
            REG_RB_COUNT:         rb_count  = value[8:0];
            REG_SINGLE_RE_ROW:    single_re = value[0];
            REG_CDM_MODE:         cdm       = cdm_type'(value[1:0]);
            REG_GAIN:             gain      = value[14:0];
            default: ;
         endcase
      endfunction

      // Elements per symbol for the current settings.
      function logic [10:0] sequence_elements();
         int unsigned blocks;
         int unsigned n;
         blocks = 32'(rb_count);
         if (blocks > MAX_BLOCKS) blocks = MAX_BLOCKS;
         n = blocks;
         if (density == DENS_HALF_EVEN || density == DENS_HALF_ODD) begin
            n = blocks / 2;
            // an odd block count adds one RB when the first RB has the right parity
            if (blocks % 2 == 1) begin
               if (density == DENS_HALF_ODD && first_rb[0]) n++;
               if (density == DENS_HALF_EVEN && !first_rb[0]) n++;
            end
         end else if (density == DENS_THREE) begin
            n = 3 * blocks;
         end
         if (cdm != CDM_NONE) n = 2 * n;
         return n[10:0];
      endfunction

      // Elements to skip before the first occupied RB.
      function int unsigned offset_elements();
         int unsigned first;
         first = 32'(first_rb);
         if (density == DENS_HALF_EVEN) first = 32'(first_rb) + 32'(first_rb[0]);
         else if (density == DENS_HALF_ODD) first = 32'(first_rb) + 32'(!first_rb[0]);
         case (density)
            DENS_THREE: return 3 * first;
            DENS_ONE:   return single_re ? first : 2 * first;
            default:    return single_re ? first / 2 : first;
         endcase
      endfunction

      function logic gold_bit();
         logic c;
         c  = x1[0] ^ x2[0];
         x1 = {x1[0] ^ x1[3], x1[30:1]};
         x2 = {x2[0] ^ x2[1] ^ x2[2] ^ x2[3], x2[30:1]};
         return c;
      endfunction

      function void take_request(op_type op, logic [8:0] slot, logic [3:0] sym,
                                 logic [2:0] port, logic [1:0] csym);
         logic [63:0]   seed;
         int unsigned   skip;
         logic [31:0]   amp;
         logic          b0;
         logic          b1;
         logic          flip;
         qpsk_elem_type e;
         if (op == OP_START) begin
            seed = 64'd1024 * (64'(ext_cp ? 12 : 14) * 64'(slot) + 64'(sym) + 64'd1)
                   * (64'd2 * 64'(scr_id) + 64'd1) + 64'(scr_id);
            x1 = 31'd1;
            x2 = seed[30:0];
            skip = WARMUP_BITS + 2 * offset_elements();
            repeat (skip) void'(gold_bit());
            port_held = port;
            csym_held = csym;
            elem_idx  = '0;
            seq_len   = sequence_elements();
         end else if (elem_idx < seq_len) begin
            amp = (32'(gain) * 32'd46341 + 32'd32768) >> 16;
            b0 = gold_bit();
            b1 = gold_bit();
            flip = 1'b0;
            case (cdm)
               CDM_FD2:     flip = port_held[0] & elem_idx[0];
               CDM_FD2_TD2: flip = (port_held[0] & elem_idx[0]) ^ (port_held[1] & csym_held[0]);
               CDM_FD2_TD4: flip = (port_held[0] & elem_idx[0]) ^ (^(port_held[2:1] & csym_held));
               default:     flip = 1'b0;
            endcase
            e.re   = (b0 ^ flip) ? -16'(amp) : 16'(amp);
            e.im   = (b1 ^ flip) ? -16'(amp) : 16'(amp);
            e.last = (elem_idx + 11'd1 == seq_len);
            awaited.push_back(e);
            elem_idx = elem_idx + 11'd1;
         end
      endfunction

      function void match_element(logic signed [15:0] re, logic signed [15:0] im,
                                  logic last);
         qpsk_elem_type want;
         if (awaited.size() == 0) begin
            $error("element with nothing expected: re_part %0d im_part %0d last %0b",
                   re, im, last);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (re !== want.re) begin
            $error("re_part mismatch: expected %0d, got %0d", want.re, re);
            errors++;
         end
         if (im !== want.im) begin
            $error("im_part mismatch: expected %0d, got %0d", want.im, im);
            errors++;
         end
         if (last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   op_type             req_op            = OP_START;
   logic [8:0]         req_slot_number   = '0;
   logic [3:0]         req_symbol_number = '0;
   logic [2:0]         req_cdm_port      = '0;
   logic [1:0]         req_cdm_symbol    = '0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic signed [15:0] rsp_re_part;
   logic signed [15:0] rsp_im_part;
   logic               rsp_last;
   logic               csr_psel          = 1'b0;
   logic               csr_penable       = 1'b0;
   logic               csr_pwrite        = 1'b0;
   logic [4:0]         csr_paddr         = '0;
   logic [31:0]        csr_pwdata        = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   csi_rs_sequence_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_slot_number   (req_slot_number),
      .req_symbol_number (req_symbol_number),
      .req_cdm_port      (req_cdm_port),
      .req_cdm_symbol    (req_cdm_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_re_part       (rsp_re_part),
      .rsp_im_part       (rsp_im_part),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   csirs_sequence_tracker tracker = new();

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the edge. Match the response first, then
   // note the request, so a beat taken at this edge never meets its own result.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.match_element(rsp_re_part, rsp_im_part, rsp_last);
         if (req_valid && !req_stall)
            tracker.take_request(req_op, req_slot_number, req_symbol_number,
                                 req_cdm_port, req_cdm_symbol);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver back-pressure: switch styles after each randomly sized span so
   // stalls land on every phase of the output, with clean stretches in between.
   // -------------------------------------------------------------------------
   int unsigned     stall_span  = 0;
   stall_style_type stall_style = STALL_NONE;

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_span  = $urandom_range(16, 200);
      end
      stall_span--;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles with no beat on any port
   // -------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request driver. The sender works in bursts; between bursts drop valid for
   // a random gap. Track sequence position here to count productive beats.
   // -------------------------------------------------------------------------
   int unsigned burst_left    = 0;
   int unsigned counted_items = 0;
   logic [10:0] walk_pos      = '0;
   logic [10:0] walk_len      = '0;

   task automatic send_request(op_type op, logic [8:0] slot, logic [3:0] sym,
                               logic [2:0] port, logic [1:0] csym);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
            @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_slot_number   <= slot;
      req_symbol_number <= sym;
      req_cdm_port      <= port;
      req_cdm_symbol    <= csym;
      // hold the beat until it is taken
      do @(posedge clock); while (!(req_valid && !req_stall));
      burst_left--;
      if (op == OP_START) begin
         counted_items++;
         walk_pos = '0;
         walk_len = tracker.sequence_elements();
      end else if (walk_pos < walk_len) begin
         counted_items++;
         walk_pos = walk_pos + 11'd1;
      end
   endtask

   // Next beats carry random junk in the fields they ignore.
   task automatic send_next_run(int unsigned beats);
      repeat (beats)
         send_request(OP_NEXT, 9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                      3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
   endtask

   task automatic send_random_start();
      send_request(OP_START, 9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                   3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
   endtask

   // Write all eight registers back to back; psel stays up across the writes.
   task automatic program_setting(logic ext, logic [9:0] ident, density_type dens,
                                  logic [8:0] first, logic [8:0] blocks, logic single,
                                  cdm_type cdm, logic [14:0] amp_gain);
      logic [31:0] word [8];
      word[REG_EXTENDED_CP]      = 32'(ext);
      word[REG_SCRAMBLING_IDENT] = 32'(ident);
      word[REG_DENSITY_MODE]     = 32'(dens);
      word[REG_FIRST_RB]         = 32'(first);
      word[REG_RB_COUNT]         = 32'(blocks);
      word[REG_SINGLE_RE_ROW]    = 32'(single);
      word[REG_CDM_MODE]         = 32'(cdm);
      word[REG_GAIN]             = 32'(amp_gain);
      for (int i = 0; i < 8; i++) begin
         // setup cycle
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {csr_index_type'(i), 2'b00};
         csr_pwdata  <= word[i];
         @(posedge clock);
         // access cycle
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         tracker.set_register(csr_index_type'(i), word[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drop valid, wait for every expected element, then let a start that
   // produces nothing finish its warm-up before anything else happens.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int unsigned phase_goal;
      int unsigned rb_pick;
      logic [10:0] len;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a next beat before any start returns nothing, then a
      // one-element sequence and a next beat past its end.
      send_next_run(1);
      send_request(OP_START, 9'd0, 4'd0, 3'd0, 2'd0);
      send_next_run(2);
      drain_pipeline();

      // Top extremes: extended CP, symbol beyond the slot, FD2 with a port
      // above 1 and a nonzero CDM symbol that must be ignored.
      program_setting(1'b1, 10'd1023, DENS_THREE, 9'd511, 9'd1, 1'b1, CDM_FD2, 15'd32767);
      send_request(OP_START, 9'd511, 4'd15, 3'd7, 2'd3);
      send_next_run(7);
      drain_pipeline();

      // Oversized block count clamps; FD2-TD2 uses only the low port bits and
      // bit 0 of the CDM symbol.
      program_setting(1'b0, 10'd0, DENS_HALF_EVEN, 9'd0, 9'd511, 1'b0, CDM_FD2_TD2, 15'd1);
      send_request(OP_START, 9'd319, 4'd13, 3'd7, 2'd3);
      send_next_run(3);
      drain_pipeline();

      // Half density on odd RBs with FD2-TD4, zero gain, CP-normal symbol 14.
      program_setting(1'b0, 10'd512, DENS_HALF_ODD, 9'd1, 9'd3, 1'b1, CDM_FD2_TD4, 15'd0);
      send_request(OP_START, 9'd256, 4'd14, 3'd6, 2'd2);
      send_next_run(5);
      drain_pipeline();

      // Random phases: fresh settings each time, mostly small allocations so
      // sequences run to their last element, now and then the largest ones.
      while (counted_items < ITEM_GOAL) begin
         rb_pick = $urandom_range(0, 19);
         program_setting(1'($urandom_range(0, 1)),
                         10'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 1023 : 0)
                                                         : $urandom_range(0, 1023)),
                         density_type'($urandom_range(0, 3)),
                         9'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 511 : 0)
                                                        : $urandom_range(0, 274)),
                         9'((rb_pick < 14) ? $urandom_range(0, 6) :
                            (rb_pick < 18) ? $urandom_range(7, 40) :
                            (rb_pick < 19) ? MAX_BLOCKS : $urandom_range(276, 511)),
                         1'($urandom_range(0, 1)),
                         cdm_type'($urandom_range(0, 3)),
                         15'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32767 : 0)
                                                         : $urandom_range(0, 32767)));
         phase_goal = counted_items + $urandom_range(60, 120);
         while (counted_items < phase_goal) begin
            pick = $urandom_range(0, 19);
            len  = tracker.sequence_elements();
            if (pick < 16) begin
               // whole sequence when short, sometimes overrun by a beat or two; else a partial run
               send_random_start();
               send_next_run((len <= 48) ? len + $urandom_range(0, 2) : $urandom_range(8, 48));
            end else if (pick < 19) begin
               // restart before the sequence is done
               send_random_start();
               send_next_run($urandom_range(0, len / 2));
            end else begin
               // stray next beats, usually past the end
               send_next_run($urandom_range(1, 4));
            end
         end
         drain_pipeline();
      end

      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/csirs_pkg.sv
hdl/csirs_seed.sv
hdl/csirs_gold.sv
hdl/csi_rs_sequence_generator.sv
sim/csi_rs_sequence_generator_test.sv
